### sv/assert_macros.svh
// assertion macros used by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// same-cycle implication
`define WCF_ASSERT_IMP(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
// next-cycle implication
`define WCF_ASSERT_NXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define WCF_ASSERT_IMP(name, clk, rst, ante, cons)
`define WCF_ASSERT_NXT(name, clk, rst, ante, cons)
`endif
`endif

### sv/wcf_pkg.sv
// types and codes for the word concatenation finder
`default_nettype none
package wcf_pkg;
   typedef enum logic [3:0] {
      ST_IDLE,
      ST_NK_RD,
      ST_NK_KEY,
      ST_LK_RD,
      ST_LK_CMP,
      ST_START,
      ST_CHK_INIT,
      ST_CK_RD,
      ST_CK_USE,
      ST_PUSH
   } wcf_state_type;

   typedef enum logic {
      MODE_NEED,
      MODE_TAG
   } wcf_mode_type;

   localparam logic REQ_LOAD = 1'b0;
   localparam logic REQ_TEXT = 1'b1;

   localparam logic [1:0] CSR_WORD_LEN   = 2'd0;
   localparam logic [1:0] CSR_WORD_COUNT = 2'd1;
endpackage
`default_nettype wire

### sv/word_concatenation_finder.sv
// word concatenation finder top level
//
//  channel  | direction | handshake           | payload
//  req_     | in        | req_valid/req_ready | type, word slot/value, text byte/first
//  rsp_     | out       | rsp_valid/rsp_ready | match_start
//  csr_     | in        | csr_valid/csr_ready | index, data
//
// one request at a time
// a text byte takes a tag lookup (one table read and compare per slot) plus a
//   window check (one segment memory read per word), both paced by the single
//   read port of each memory
// a first byte also counts the needed words before its own lookup
// reset is synchronous; table and segment memories need no clearing
// a match waits in the output register; a new request is taken while it waits
`default_nettype none
`include "assert_macros.svh"
module word_concatenation_finder
   import wcf_pkg::*;
#(
   parameter int MAX_WORDS    = 16,
   parameter int MAX_WORD_LEN = 8,
   parameter int POS_BITS     = 16
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic        req_type,
   input  wire logic [3:0]  req_word_slot,
   input  wire logic [63:0] req_word_value,
   input  wire logic [7:0]  req_text_byte,
   input  wire logic        req_text_first,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [15:0]      rsp_match_start,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [1:0]  csr_index,
   input  wire logic [7:0]  csr_data
);
   localparam int DEPTH     = MAX_WORDS * MAX_WORD_LEN;
   localparam int SLOT_BITS = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;
   localparam int CNT_BITS  = $clog2(MAX_WORDS + 1);
   localparam int SEG_BITS  = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   // state machine and control
   wcf_state_type state_ff, state_in;
   wcf_mode_type  mode_ff, mode_in;
   logic [SLOT_BITS-1:0] j_ff, j_in, k_ff, k_in, m_ff, m_in;
   logic [63:0] key_ff, key_in;
   logic [7:0]  byte_ff, byte_in;
   logic [63:0] recent_ff, recent_in;
   logic [POS_BITS-1:0] pos_ff, pos_in, p_ff, p_in;
   logic [SEG_BITS-1:0] wp_ff, wp_in, ck_addr_ff, ck_addr_in;
   logic [CNT_BITS-1:0] needed_ff [MAX_WORDS];
   logic [CNT_BITS-1:0] needed_in [MAX_WORDS];
   logic [CNT_BITS-1:0] seen_ff [MAX_WORDS];
   logic [CNT_BITS-1:0] seen_in [MAX_WORDS];
   logic        rsp_valid_ff, rsp_valid_in;
   logic [15:0] match_ff, match_in;
   logic [3:0]  cfg_len_ff, cfg_len_in;
   logic [4:0]  cfg_cnt_ff, cfg_cnt_in;

   // memories
   logic [63:0]         tbl_mem [MAX_WORDS];
   logic [63:0]         tbl_q;
   logic [SLOT_BITS-1:0] tbl_rd_addr;
   logic [CNT_BITS-1:0] seg_mem [DEPTH];
   logic [CNT_BITS-1:0] seg_q;
   logic                seg_we;
   logic [CNT_BITS-1:0] seg_wdata;

   // derived values
   logic [3:0]          eff_len;
   logic [CNT_BITS-1:0] eff_cnt;
   logic [SLOT_BITS-1:0] last_slot;
   logic [63:0]         mask;
   logic                hit;
   logic [63:0]         recent_new;
   logic [6:0]          shift;
   logic [POS_BITS:0]   p_plus, pos_plus;
   logic [11:0]         total;
   logic                window_ok, tag_ok, saturated;
   logic [POS_BITS-1:0] start;
   logic [31:0]         start_wide;
   logic                id_bad, over;
   logic [SLOT_BITS-1:0] idx;
   logic [SEG_BITS:0]   addr_ext, addr_step;
   logic [SLOT_BITS-1:0] load_slot;
   logic                req_acc, push_ok;

   assign req_acc = req_valid && req_ready;
   assign load_slot = SLOT_BITS'(32'(req_word_slot) % MAX_WORDS);
   assign push_ok = !rsp_valid_ff || rsp_ready;

   // out-of-range registers clamp to the legal span
   always_comb begin
      if (cfg_len_ff == 4'd0) begin
         eff_len = 4'd1;
      end else if (32'(cfg_len_ff) > MAX_WORD_LEN) begin
         eff_len = 4'(MAX_WORD_LEN);
      end else begin
         eff_len = cfg_len_ff;
      end
      if (cfg_cnt_ff == 5'd0) begin
         eff_cnt = CNT_BITS'(1);
      end else if (32'(cfg_cnt_ff) > MAX_WORDS) begin
         eff_cnt = CNT_BITS'(MAX_WORDS);
      end else begin
         eff_cnt = CNT_BITS'(cfg_cnt_ff);
      end
   end
   assign last_slot = SLOT_BITS'(eff_cnt - CNT_BITS'(1));

   // only the low word_len bytes take part in a compare
   always_comb begin
      for (int b = 0; b < 8; b++) begin
         mask[8*b +: 8] = (4'(b) < eff_len) ? 8'hFF : 8'h00;
      end
   end
   assign hit = (tbl_q & mask) == (key_ff & mask);

   // newest byte enters at the top; the word ending here sits in the top bytes
   assign recent_new = {byte_ff, recent_ff[63:8]};
   assign shift      = 7'd64 - {eff_len[3:0], 3'b000};
   assign pos_plus   = {1'b0, pos_ff} + (POS_BITS+1)'(1);
   assign p_plus     = {1'b0, p_ff} + (POS_BITS+1)'(1);
   assign saturated  = pos_ff == {POS_BITS{1'b1}};
   assign tag_ok     = pos_plus >= (POS_BITS+1)'(eff_len);
   assign total      = 12'(eff_len) * 12'(eff_cnt);
   assign window_ok  = 33'(p_plus) >= 33'(total);
   assign start      = POS_BITS'(p_plus - (POS_BITS+1)'(total));
   assign start_wide = 32'(start);

   // window check on the segment just read
   assign id_bad = seg_q >= CNT_BITS'(MAX_WORDS);
   assign idx    = SLOT_BITS'(seg_q);
   assign over   = id_bad ? 1'b1 : (seen_ff[idx] >= needed_ff[idx]);

   // step back one word in the circular segment memory
   always_comb begin
      addr_ext = {1'b0, ck_addr_ff};
      if (addr_ext >= (SEG_BITS+1)'(eff_len)) begin
         addr_step = addr_ext - (SEG_BITS+1)'(eff_len);
      end else begin
         addr_step = addr_ext + (SEG_BITS+1)'(DEPTH) - (SEG_BITS+1)'(eff_len);
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_acc && req_type == REQ_TEXT) begin
               state_in = req_text_first ? ST_NK_RD : ST_START;
            end
         end
         ST_NK_RD:  state_in = ST_NK_KEY;
         ST_NK_KEY: state_in = ST_LK_RD;
         ST_LK_RD:  state_in = ST_LK_CMP;
         ST_LK_CMP: begin
            if (hit || j_ff == last_slot) begin
               if (mode_ff == MODE_TAG) begin
                  state_in = ST_CHK_INIT;
               end else if (k_ff == last_slot) begin
                  state_in = ST_START;
               end else begin
                  state_in = ST_NK_RD;
               end
            end else begin
               state_in = ST_LK_RD;
            end
         end
         ST_START: begin
            if (saturated) begin
               state_in = ST_IDLE;
            end else if (tag_ok) begin
               state_in = ST_LK_RD;
            end else begin
               state_in = ST_CHK_INIT;
            end
         end
         ST_CHK_INIT: state_in = window_ok ? ST_CK_RD : ST_IDLE;
         ST_CK_RD:    state_in = ST_CK_USE;
         ST_CK_USE: begin
            if (over) begin
               state_in = ST_IDLE;
            end else if (m_ff == last_slot) begin
               state_in = ST_PUSH;
            end else begin
               state_in = ST_CK_RD;
            end
         end
         ST_PUSH: state_in = push_ok ? ST_IDLE : ST_PUSH;
         default: state_in = ST_IDLE;
      endcase
   end

   // datapath next values
   always_comb begin
      mode_in    = mode_ff;
      j_in       = j_ff;
      k_in       = k_ff;
      m_in       = m_ff;
      key_in     = key_ff;
      byte_in    = byte_ff;
      recent_in  = recent_ff;
      pos_in     = pos_ff;
      p_in       = p_ff;
      wp_in      = wp_ff;
      ck_addr_in = ck_addr_ff;
      needed_in  = needed_ff;
      seen_in    = seen_ff;
      match_in   = match_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      seg_we     = 1'b0;
      seg_wdata  = CNT_BITS'(MAX_WORDS);
      tbl_rd_addr = (state_ff == ST_NK_RD) ? k_ff : j_ff;
      cfg_len_in = cfg_len_ff;
      cfg_cnt_in = cfg_cnt_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_WORD_LEN:   cfg_len_in = csr_data[3:0];
            CSR_WORD_COUNT: cfg_cnt_in = csr_data[4:0];
            default: ;
         endcase
      end
      case (state_ff)
         ST_IDLE: begin
            if (req_acc && req_type == REQ_TEXT) begin
               byte_in = req_text_byte;
               if (req_text_first) begin
                  pos_in    = '0;
                  recent_in = '0;
                  wp_in     = '0;
                  k_in      = '0;
                  for (int i = 0; i < MAX_WORDS; i++) begin
                     needed_in[i] = '0;
                  end
               end
            end
         end
         ST_NK_KEY: begin
            key_in  = tbl_q;
            j_in    = '0;
            mode_in = MODE_NEED;
         end
         ST_LK_CMP: begin
            if (hit || j_ff == last_slot) begin
               if (mode_ff == MODE_TAG) begin
                  seg_we    = 1'b1;
                  seg_wdata = hit ? CNT_BITS'(j_ff) : CNT_BITS'(MAX_WORDS);
               end else begin
                  if (hit) begin
                     needed_in[j_ff] = needed_ff[j_ff] + CNT_BITS'(1);
                  end
                  k_in = k_ff + SLOT_BITS'(1);
               end
            end else begin
               j_in = j_ff + SLOT_BITS'(1);
            end
         end
         ST_START: begin
            if (!saturated) begin
               p_in      = pos_ff;
               pos_in    = POS_BITS'(pos_plus);
               recent_in = recent_new;
               if (tag_ok) begin
                  key_in  = recent_new >> shift;
                  j_in    = '0;
                  mode_in = MODE_TAG;
               end else begin
                  seg_we    = 1'b1;
                  seg_wdata = CNT_BITS'(MAX_WORDS);
               end
            end
         end
         ST_CHK_INIT: begin
            ck_addr_in = wp_ff;
            wp_in = (32'(wp_ff) == DEPTH - 1) ? '0 : wp_ff + SEG_BITS'(1);
            m_in = '0;
            for (int i = 0; i < MAX_WORDS; i++) begin
               seen_in[i] = '0;
            end
         end
         ST_CK_USE: begin
            if (!over) begin
               seen_in[idx] = seen_ff[idx] + CNT_BITS'(1);
               m_in       = m_ff + SLOT_BITS'(1);
               ck_addr_in = SEG_BITS'(addr_step);
            end
         end
         ST_PUSH: begin
            if (push_ok) begin
               rsp_valid_in = 1'b1;
               match_in     = start_wide[15:0];
            end
         end
         default: ;
      endcase
   end

   // outputs
   always_comb begin
      req_ready       = state_ff == ST_IDLE;
      rsp_valid       = rsp_valid_ff;
      rsp_match_start = match_ff;
      csr_ready       = 1'b1;
   end

   // memories: one write and one registered read each
   always_ff @(posedge clock) begin
      if (req_acc && req_type == REQ_LOAD) begin
         tbl_mem[load_slot] <= req_word_value;
      end
      tbl_q <= tbl_mem[tbl_rd_addr];
   end

   always_ff @(posedge clock) begin
      if (seg_we) begin
         seg_mem[wp_ff] <= seg_wdata;
      end
      seg_q <= seg_mem[ck_addr_ff];
   end

   // registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         pos_ff       <= '0;
         recent_ff    <= '0;
         wp_ff        <= '0;
         cfg_len_ff   <= 4'd1;
         cfg_cnt_ff   <= 5'd1;
         for (int i = 0; i < MAX_WORDS; i++) begin
            needed_ff[i] <= '0;
            seen_ff[i]   <= '0;
         end
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         pos_ff       <= pos_in;
         recent_ff    <= recent_in;
         wp_ff        <= wp_in;
         cfg_len_ff   <= cfg_len_in;
         cfg_cnt_ff   <= cfg_cnt_in;
         needed_ff    <= needed_in;
         seen_ff      <= seen_in;
      end
   end

   always_ff @(posedge clock) begin
      mode_ff    <= mode_in;
      j_ff       <= j_in;
      k_ff       <= k_in;
      m_ff       <= m_in;
      key_ff     <= key_in;
      byte_ff    <= byte_in;
      p_ff       <= p_in;
      ck_addr_ff <= ck_addr_in;
      match_ff   <= match_in;
   end

   // checks
   `WCF_ASSERT_IMP(a_check_bound, clock, reset, state_ff == ST_CK_USE, m_ff <= last_slot)
   `WCF_ASSERT_NXT(a_push_loads, clock, reset, state_ff == ST_PUSH && push_ok, rsp_valid_ff)
   `WCF_ASSERT_IMP(a_wp_range, clock, reset, 1'b1, 32'(wp_ff) < DEPTH)
endmodule
`default_nettype wire

### verif/word_concatenation_finder_test.sv
// testbench for the word concatenation finder: queued stimulus, predictor and checker
`timescale 1ns / 100ps
`default_nettype none
module word_concatenation_finder_test
   import wcf_pkg::*;
();

   localparam int SLOTS     = 16;
   localparam int SEG_DEPTH = 128;
   localparam int NONE_ID   = 16;
   localparam int POS_LIMIT = 65535;
   localparam int SETTLE    = 800;   // covers a first byte at 16 words plus a stalled response
   localparam int WATCHDOG  = 5000;

   typedef struct packed {
      logic        kind;
      logic [3:0]  slot;
      logic [63:0] value;
      logic [7:0]  tbyte;
      logic        first;
   } request_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic        req_type = REQ_LOAD;
   logic [3:0]  req_word_slot = '0;
   logic [63:0] req_word_value = '0;
   logic [7:0]  req_text_byte = '0;
   logic        req_text_first = 1'b0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [15:0] rsp_match_start;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [1:0]  csr_index = CSR_WORD_LEN;
   logic [7:0]  csr_data = '0;

   word_concatenation_finder dut (.*);

   always #5 clock = ~clock;

   // pending requests and expected match starts
   request_type pending_q[$];
   logic [15:0] start_q[$];

   // predictor copy of the block state
   logic [63:0] table_copy [SLOTS];
   int          need_copy [SLOTS];
   int          seg_copy [SEG_DEPTH];
   logic [63:0] last_bytes;
   int          position;
   logic [3:0]  len_reg;
   logic [4:0]  count_reg;

   int errors = 0;
   int match_total = 0;
   int texts = 0;

   function automatic int eff_len();
      if (len_reg < 1) return 1;
      if (len_reg > 8) return 8;
      return len_reg;
   endfunction

   function automatic int eff_count();
      if (count_reg < 1) return 1;
      if (count_reg > SLOTS) return SLOTS;
      return count_reg;
   endfunction

   function automatic logic [63:0] len_mask(int w);
      if (w >= 8) return '1;
      return (64'd1 << (8 * w)) - 1;
   endfunction

   // lowest slot in use holding this word
   function automatic int find_slot(logic [63:0] v, int w, int c);
      logic [63:0] m;
      m = len_mask(w);
      for (int j = 0; j < c; j++)
         if ((table_copy[j] & m) == (v & m)) return j;
      return NONE_ID;
   endfunction

   // apply one accepted request and queue the match it causes
   task automatic predict_match(request_type r);
      int w, c, p, total, st, id;
      int seen [SLOTS];
      bit hit;
      if (r.kind == REQ_LOAD) begin
         table_copy[r.slot] = r.value;
         return;
      end
      w = eff_len();
      c = eff_count();
      if (r.first) begin
         position = 0;
         last_bytes = '0;
         for (int j = 0; j < SLOTS; j++) need_copy[j] = 0;
         for (int k = 0; k < c; k++) begin
            id = find_slot(table_copy[k], w, c);
            if (id < SLOTS) need_copy[id]++;
         end
      end
      if (position >= POS_LIMIT) return;
      p = position;
      position++;
      last_bytes = {r.tbyte, last_bytes[63:8]};
      if (p + 1 >= w) seg_copy[p % SEG_DEPTH] = find_slot(last_bytes >> (64 - 8 * w), w, c);
      else seg_copy[p % SEG_DEPTH] = NONE_ID;
      total = w * c;
      if (p + 1 < total) return;
      st = p + 1 - total;
      for (int j = 0; j < SLOTS; j++) seen[j] = 0;
      hit = 1;
      for (int k = 0; k < c && hit; k++) begin
         id = seg_copy[(st + w * k + w - 1) % SEG_DEPTH];
         if (id >= SLOTS) hit = 0;
         else begin
            seen[id]++;
            if (seen[id] > need_copy[id]) hit = 0;
         end
      end
      if (hit) start_q = {start_q, st[15:0]};
   endtask

   // driver: bursts of requests with random gaps
   int burst_left = 0;
   int gap_left = 0;
   always @(posedge clock) begin
      request_type r;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_ready) begin
         if (gap_left > 0) begin
            gap_left <= gap_left - 1;
            req_valid <= 1'b0;
         end else if (pending_q.size() != 0) begin
            r = pending_q.pop_front();
            req_type <= r.kind;
            req_word_slot <= r.slot;
            req_word_value <= r.value;
            req_text_byte <= r.tbyte;
            req_text_first <= r.first;
            req_valid <= 1'b1;
            if (burst_left <= 1) begin
               burst_left <= $urandom_range(1, 24);
               // some bursts run back to back
               gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 9);
            end else begin
               burst_left <= burst_left - 1;
               gap_left <= 0;
            end
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // receiver: alternating windows of steady ready and random stalls
   int rx_cycle = 0;
   always @(posedge clock) begin
      rx_cycle <= rx_cycle + 1;
      if (reset) rsp_ready <= 1'b0;
      else if (rx_cycle[8]) rsp_ready <= 1'b1;
      else if (rx_cycle[7]) rsp_ready <= ($urandom_range(0, 3) != 0);
      else rsp_ready <= ($urandom_range(0, 2) == 0);
   end

   // monitor: check responses, then predict for the accepted request
   always @(posedge clock) begin
      logic [15:0] want;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (start_q.size() == 0) begin
               $display("%0t: unexpected match, expected none, actual start %0d",
                        $time, rsp_match_start);
               errors++;
            end else begin
               want = start_q.pop_front();
               match_total++;
               if (want !== rsp_match_start) begin
                  $display("%0t: match_start mismatch, expected %0d, actual %0d",
                           $time, want, rsp_match_start);
                  errors++;
               end
            end
         end
         if (req_valid && req_ready)
            predict_match('{req_type, req_word_slot, req_word_value,
                            req_text_byte, req_text_first});
      end
   end

   // watchdog on cycles without any handshake
   int quiet = 0;
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)
          || (csr_valid && csr_ready)) begin
         quiet <= 0;
      end else if (quiet >= WATCHDOG) begin
         $display("%0t: timeout, %0d requests and %0d matches outstanding",
                  $time, pending_q.size(), start_q.size());
         $display("DONE: errors detected");
         $finish;
      end else begin
         quiet <= quiet + 1;
      end
   end

   task automatic write_csr(logic [1:0] idx, logic [7:0] data);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      if (idx == CSR_WORD_LEN) len_reg = data[3:0];
      else count_reg = data[4:0];
      csr_valid <= 1'b0;
   endtask

   // wait for the block to go idle before touching registers
   task automatic drain();
      while (pending_q.size() != 0 || req_valid || start_q.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic push_load(int slot, logic [63:0] v);
      request_type r;
      r = '{REQ_LOAD, slot[3:0], v, 8'($urandom), 1'($urandom)};
      pending_q = {pending_q, r};
   endtask

   task automatic push_byte(logic [7:0] b, bit first);
      request_type r;
      r = '{REQ_TEXT, 4'($urandom), {$urandom, $urandom}, b, first};
      pending_q = {pending_q, r};
      if (first) texts++;
   endtask

   function automatic logic [7:0] letter();
      return ($urandom_range(0, 1) == 0) ? 8'h61 : 8'h62;
   endfunction

   // one phase of random table content and texts
   task automatic random_phase(logic [7:0] len_data, logic [7:0] count_data, int n_items);
      logic [63:0] words [SLOTS];
      logic [63:0] pool [SLOTS];
      int w, c, n_pool, start_len, pick;
      int order [SLOTS];
      write_csr(CSR_WORD_LEN, len_data);
      write_csr(CSR_WORD_COUNT, count_data);
      w = eff_len();
      c = eff_count();
      n_pool = $urandom_range(1, c);
      for (int i = 0; i < n_pool; i++) begin
         pool[i] = '0;
         for (int b = 0; b < w; b++) pool[i][8 * b +: 8] = letter();
      end
      for (int s = 0; s < SLOTS; s++) begin
         words[s] = pool[$urandom_range(0, n_pool - 1)];
         // garbage above the word length must be ignored
         if ($urandom_range(0, 3) == 0) words[s] |= {$urandom, $urandom} & ~len_mask(w);
         push_load(s, words[s]);
      end
      start_len = pending_q.size();
      while (pending_q.size() - start_len < n_items) begin
         push_byte(letter(), 1'b1);
         repeat ($urandom_range(2, 6)) begin
            pick = $urandom_range(0, 9);
            if (pick < 5) begin
               // whole concatenation in a shuffled order
               for (int k = 0; k < c; k++) order[k] = k;
               for (int k = c - 1; k > 0; k--) begin
                  int j, t;
                  j = $urandom_range(0, k);
                  t = order[k]; order[k] = order[j]; order[j] = t;
               end
               for (int k = 0; k < c; k++)
                  for (int b = 0; b < w; b++) push_byte(words[order[k]][8 * b +: 8], 1'b0);
            end else if (pick < 8) begin
               repeat ($urandom_range(1, 2 * w))
                  push_byte(($urandom_range(0, 7) == 0) ? 8'($urandom) : letter(), 1'b0);
            end else if (pick == 8) begin
               // table change in the middle of a text
               pick = $urandom_range(0, SLOTS - 1);
               words[pick] = pool[$urandom_range(0, n_pool - 1)];
               push_load(pick, words[pick]);
            end else begin
               for (int b = 0; b < w; b++) push_byte(words[$urandom_range(0, c - 1)][8 * b +: 8],
                                                      1'b0);
            end
         end
      end
      drain();
   endtask

   initial begin
      last_bytes = '0;
      position = 0;
      len_reg = 4'd1;
      count_reg = 5'd1;
      for (int j = 0; j < SLOTS; j++) begin
         table_copy[j] = '0;
         need_copy[j] = 0;
      end
      for (int j = 0; j < SEG_DEPTH; j++) seg_copy[j] = NONE_ID;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // directed: extreme slots and values, text before any first byte
      write_csr(CSR_WORD_LEN, 8'd1);
      write_csr(CSR_WORD_COUNT, 8'd1);
      push_load(0, '1);
      push_load(15, '0);
      for (int s = 1; s < 15; s++) push_load(s, {$urandom, $urandom});
      push_byte(8'hFF, 1'b0);
      push_byte(8'h00, 1'b0);
      push_byte(8'hFF, 1'b0);
      push_byte(8'h00, 1'b1);
      push_byte(8'hFF, 1'b0);
      push_byte(8'hFF, 1'b1);
      drain();

      // extremes, out of range codes with upper data bits set, then random settings
      random_phase(8'd1, 8'd1, 120);
      random_phase(8'd8, 8'd16, 260);
      random_phase(8'hF0, 8'hE0, 120);   // zero after masking acts as one
      random_phase(8'h0F, 8'h1F, 200);   // above the maximum acts as the maximum
      random_phase(8'd9, 8'd17, 200);
      repeat (4)
         random_phase(8'($urandom_range(1, 8)) | (8'($urandom) & 8'hF0),
                      8'($urandom_range(1, 16)) | (8'($urandom) & 8'hE0), 120);

      // a single-letter word over a longer text, then a restart mid stream
      write_csr(CSR_WORD_LEN, 8'd1);
      write_csr(CSR_WORD_COUNT, 8'd1);
      push_load(0, 64'h41);
      push_byte(8'h41, 1'b1);
      for (int i = 0; i < 60; i++)
         push_byte(($urandom_range(0, 7) == 0) ? 8'h41 : 8'h42, 1'b0);
      push_byte(8'h41, 1'b1);
      push_byte(8'h41, 1'b0);
      drain();

      $display("covered %0d texts over extreme and random word lengths and counts,", texts);
      $display("%0d matches checked, with table changes inside texts", match_total);
      if (errors == 0 && start_q.size() == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end
endmodule
`default_nettype wire
